### rtl/srd_pkg.sv
// Shared types and constants for the run-length sprite row decoder.
package srd_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned RUN_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 1'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_FINISHED = 2'd0,
    PH_HEADER   = 2'd1,
    PH_LITERAL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] rle_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    kind_t               kind;
    logic [9:0]          pixel_x;
    logic [9:0]          pixel_y;
    logic [7:0]          pixel_value;
    logic                run_end;
    logic [COUNT_W-1:0]  bytes_used;
  } out_t;

endpackage

### rtl/srd_cfg.sv
// One sprite size register with clamping of written values.
module srd_cfg #(
  parameter int unsigned MAX_VAL = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [srd_pkg::CFG_DATA_W-1:0] wr_data,
  output logic [((MAX_VAL >= 2047) ? 11 : $clog2(MAX_VAL + 1))-1:0] value
);
  import srd_pkg::*;

  localparam int unsigned VAL_W = (MAX_VAL >= 2047) ? 11 : $clog2(MAX_VAL + 1);
  localparam int unsigned CAP   = (MAX_VAL > 2047) ? 2047 : MAX_VAL;
  localparam logic [CFG_DATA_W-1:0] CAP_D = CFG_DATA_W'(CAP);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // zero becomes one, anything above the cap becomes the cap
  always_comb begin
    if (wr_data == '0) begin
      val_nxt = VAL_W'(1);
    end else if (wr_data > CAP_D) begin
      val_nxt = VAL_W'(CAP);
    end else begin
      val_nxt = VAL_W'(wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= VAL_W'(1);
    end else if (wr_en) begin
      val_r <= val_nxt;
    end
  end

  assign value = val_r;

endmodule

### rtl/sprite_rle_row_decoder_unit.sv
// Top level of the run-length sprite row decoder.
//
// Usage:
//   Feed the sprite stream one byte per beat on in_*; set first_byte on the
//   first byte of each sprite. Each literal byte yields one pixel write beat
//   on out_*; the zero header of the last row yields a done beat carrying
//   the byte count; a run or skip wider than the room left in its row
//   yields an error beat. Headers, skips and non-last row ends give no beat.
//   Set sprite width and height on cfg_* (index 0 width, 1 height) while
//   the decoder is idle; cfg_ready is always high.
// Timing:
//   A result appears on out_* the cycle after its byte is taken. One byte is
//   taken every cycle; the decode of a byte is a single pass through the
//   header/literal logic into the output register, so the rate is one byte
//   per cycle as long as the receiver keeps up.
// Stall and reset:
//   While out_stall holds a waiting result, in_stall rises and the result is
//   held. Reset clears the decoder to the finished state, sizes to 1, and
//   drops any waiting result; bytes are ignored until a first byte arrives.
module sprite_rle_row_decoder_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  srd_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output srd_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srd_pkg::*;

  localparam int unsigned W_W   = (MAX_WIDTH >= 2047) ? 11 : $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W   = (MAX_HEIGHT >= 2047) ? 11 : $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CMP_W = ((W_W > 8) ? W_W : 8) + 1;

  logic [W_W-1:0]     width;
  logic [H_W-1:0]     height;

  phase_t             phase_r, phase_nxt;
  logic [RUN_W-1:0]   lit_r, lit_nxt;
  logic [W_W-1:0]     col_r, col_nxt;
  logic [H_W-1:0]     row_r, row_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, res;
  logic               res_valid;

  logic               in_acc;
  phase_t             ph_eff;
  logic [RUN_W-1:0]   lit_eff;
  logic [W_W-1:0]     col_eff;
  logic [H_W-1:0]     row_eff;
  logic [COUNT_W-1:0] cnt_eff, cnt_inc;
  logic [H_W:0]       row_inc;
  logic [7:0]         mag;
  logic [CMP_W-1:0]   room;
  logic               too_wide;
  logic [7:0]         b;

  assign cfg_ready = 1'b1;

  srd_cfg #(.MAX_VAL(MAX_WIDTH)) u_width (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_index == REG_SPRITE_WIDTH),
    .wr_data (cfg_data),
    .value   (width)
  );

  srd_cfg #(.MAX_VAL(MAX_HEIGHT)) u_height (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_index == REG_SPRITE_HEIGHT),
    .wr_data (cfg_data),
    .value   (height)
  );

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign b        = in_data.rle_byte;

  // a first-byte mark restarts from a clean header state
  always_comb begin
    if (in_data.first_byte) begin
      ph_eff  = PH_HEADER;
      lit_eff = '0;
      col_eff = '0;
      row_eff = '0;
      cnt_eff = '0;
    end else begin
      ph_eff  = phase_r;
      lit_eff = lit_r;
      col_eff = col_r;
      row_eff = row_r;
      cnt_eff = cnt_r;
    end
  end

  assign cnt_inc  = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + COUNT_W'(1);
  assign row_inc  = {1'b0, row_eff} + (H_W+1)'(1);
  assign mag      = b[7] ? (~b + 8'd1) : b;
  // a column already past the width leaves no room
  assign room     = (CMP_W'(col_eff) <= CMP_W'(width)) ?
                    CMP_W'(width) - CMP_W'(col_eff) : '0;
  assign too_wide = CMP_W'(mag) > room;

  // next state
  always_comb begin
    phase_nxt = ph_eff;
    lit_nxt   = lit_eff;
    col_nxt   = col_eff;
    row_nxt   = row_eff;
    cnt_nxt   = cnt_eff;
    case (ph_eff)
      PH_LITERAL: begin
        cnt_nxt = cnt_inc;
        col_nxt = col_eff + W_W'(1);
        lit_nxt = lit_eff - RUN_W'(1);
        if (lit_eff == RUN_W'(1)) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        cnt_nxt = cnt_inc;
        if (b == 8'd0) begin
          row_nxt = H_W'(row_inc);
          col_nxt = '0;
          if (row_inc >= (H_W+1)'(height)) begin
            phase_nxt = PH_FINISHED;
          end
        end else if (too_wide) begin
          phase_nxt = PH_FINISHED;
          lit_nxt   = '0;
        end else if (b[7]) begin
          col_nxt = col_eff + W_W'(mag);
        end else begin
          lit_nxt   = b[RUN_W-1:0];
          phase_nxt = PH_LITERAL;
        end
      end
      default: begin
      end
    endcase
  end

  // result for this byte
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (ph_eff)
      PH_LITERAL: begin
        res_valid       = 1'b1;
        res.kind        = KIND_PIXEL;
        res.pixel_x     = 10'(col_eff);
        res.pixel_y     = 10'(row_eff);
        res.pixel_value = b;
        res.run_end     = (lit_eff == RUN_W'(1));
      end
      PH_HEADER: begin
        if (b == 8'd0) begin
          if (row_inc >= (H_W+1)'(height)) begin
            res_valid      = 1'b1;
            res.kind       = KIND_DONE;
            res.bytes_used = cnt_inc;
          end
        end else if (too_wide) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (in_acc && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FINISHED;
      lit_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r <= phase_nxt;
        lit_r   <= lit_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_literal_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LITERAL |-> lit_r != '0)
    else $error("literal phase with no bytes left");

  a_active_counted: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_FINISHED |-> cnt_r != '0)
    else $error("active decode with zero byte count");

  a_first_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.first_byte |=> phase_r != PH_FINISHED || out_valid_r)
    else $error("first byte neither started decode nor gave a result");
`endif

endmodule
